[rtl/kdsc_pkg.sv]
// Shared types, constants and codes for the key debounce speed command block.
package kdsc_pkg;

  localparam int unsigned DefKeyCount = 5;
  localparam int unsigned ActKeys     = 5;

  localparam int unsigned CntW   = 8;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned StepW  = 10;
  localparam int unsigned EvtW   = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0]          DebounceRst = 8'd5;
  localparam logic signed [SpeedW-1:0] StartRst    = 16'sd60;
  localparam logic [StepW-1:0]         StepRst     = 10'd5;

  typedef enum logic [EvtW-1:0] {
    EV_NONE    = 3'd0,
    EV_START   = 3'd1,
    EV_STOP    = 3'd2,
    EV_FASTER  = 3'd3,
    EV_SLOWER  = 3'd4,
    EV_REVERSE = 3'd5
  } evt_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_START    = 2'd1,
    CFG_STEP     = 2'd2
  } cfg_idx_e;

  // Keys above the fifth report events but drive no speed or enable action.
  typedef struct packed {
    logic            hit;
    logic            act;
    logic [EvtW-1:0] code;
  } scan_res_t;

endpackage

[rtl/kdsc_scan.sv]
// Per-key debounce counters and pressed flags with a priority scan for the press event.
module kdsc_scan import kdsc_pkg::*; #(
  parameter int unsigned KEY_COUNT = DefKeyCount
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [KEY_COUNT-1:0] levels_i,
  input  logic [CntW-1:0]      debounce_i,
  output scan_res_t            res_o
);

  logic [CntW-1:0] cnt_q [KEY_COUNT];
  logic [CntW-1:0] cnt_d [KEY_COUNT];
  logic [CntW-1:0] cnt_n [KEY_COUNT];
  logic [KEY_COUNT-1:0] prs_q;
  logic [KEY_COUNT-1:0] prs_d;

  always_comb begin
    for (int k = 0; k < KEY_COUNT; k++) begin
      cnt_n[k] = (cnt_q[k] < debounce_i) ? cnt_q[k] + CntW'(1) : cnt_q[k];
    end
  end

  always_comb begin
    res_o = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      cnt_d[k] = cnt_q[k];
      prs_d[k] = prs_q[k];
      if (!res_o.hit) begin
        if (levels_i[k]) begin
          cnt_d[k] = cnt_n[k];
          if (cnt_n[k] >= debounce_i && !prs_q[k]) begin
            prs_d[k]   = 1'b1;
            res_o.hit  = 1'b1;
            res_o.act  = (k < ActKeys);
            res_o.code = EvtW'(k + 1);
          end
        end else begin
          cnt_d[k] = '0;
          prs_d[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        cnt_q[k] <= '0;
      end
      prs_q <= '0;
    end else if (step_i) begin
      cnt_q <= cnt_d;
      prs_q <= prs_d;
    end
  end

endmodule

[rtl/key_debounce_speed_command_core.sv]
// Top level of the key debounce speed command block.
// A result is presented in the cycle after its input transfer.
// Throughput: one input transfer per cycle while results are taken.
// The scan and the set-point update are combinational between the input port
// and the result register.
// Reset clears counters, pressed flags, set-point and enable, and loads register defaults.
module key_debounce_speed_command_core import kdsc_pkg::*; #(
  parameter int unsigned KEY_COUNT = DefKeyCount
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [KEY_COUNT-1:0]     key_levels_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [EvtW-1:0]          press_event_o,
  output logic signed [SpeedW-1:0] speed_setpoint_o,
  output logic                     motor_enabled_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIdxW-1:0]       cfg_index_i,
  input  logic [CfgDataW-1:0]      cfg_data_i
);

  logic                     acc;
  scan_res_t                scan;
  logic [EvtW-1:0]          act_code;
  logic [CntW-1:0]          dbc_q;
  logic signed [SpeedW-1:0] start_q;
  logic [StepW-1:0]         step_q;
  logic signed [SpeedW-1:0] speed_q;
  logic signed [SpeedW-1:0] speed_d;
  logic                     en_q;
  logic                     en_d;
  logic                     out_valid_q;
  logic [EvtW-1:0]          evt_q;
  logic signed [SpeedW:0]   wide;
  logic signed [SpeedW:0]   sum;

  localparam logic signed [SpeedW:0] MaxWide = (SpeedW+1)'(2 ** (SpeedW - 1) - 1);
  localparam logic signed [SpeedW:0] MinWide = -(SpeedW+1)'(2 ** (SpeedW - 1));

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign acc         = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  kdsc_scan #(
    .KEY_COUNT(KEY_COUNT)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (acc),
    .levels_i  (key_levels_i),
    .debounce_i(dbc_q),
    .res_o     (scan)
  );

  assign act_code = scan.act ? scan.code : EV_NONE;
  assign wide     = {speed_q[SpeedW-1], speed_q};

  always_comb begin
    speed_d = speed_q;
    en_d    = en_q;
    sum     = wide;
    case (act_code) inside
      EV_START: begin
        speed_d = start_q;
        en_d    = 1'b1;
      end
      EV_STOP: begin
        en_d = 1'b0;
      end
      EV_FASTER, EV_SLOWER, EV_REVERSE: begin
        if (act_code == EV_FASTER) begin
          sum = wide + {{(SpeedW+1-StepW){1'b0}}, step_q};
        end else if (act_code == EV_SLOWER) begin
          sum = wide - {{(SpeedW+1-StepW){1'b0}}, step_q};
        end else begin
          sum = -wide;
        end
        if (sum > MaxWide) begin
          speed_d = MaxWide[SpeedW-1:0];
        end else if (sum < MinWide) begin
          speed_d = MinWide[SpeedW-1:0];
        end else begin
          speed_d = sum[SpeedW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbc_q   <= DebounceRst;
      start_q <= StartRst;
      step_q  <= StepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE: dbc_q   <= cfg_data_i[CntW-1:0];
        CFG_START:    start_q <= cfg_data_i[SpeedW-1:0];
        CFG_STEP:     step_q  <= cfg_data_i[StepW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q     <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc) begin
        speed_q     <= speed_d;
        en_q        <= en_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      evt_q <= scan.code;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign press_event_o    = evt_q;
  assign speed_setpoint_o = speed_q;
  assign motor_enabled_o  = en_q;

  a_start_enables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && act_code == EV_START) |=> (motor_enabled_o && speed_setpoint_o == $past(start_q)))
    else $error("start transfer did not enable the motor");

  a_stop_disables: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && act_code == EV_STOP) |=> !motor_enabled_o)
    else $error("stop transfer did not disable the motor");

  a_reverse_negates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && act_code == EV_REVERSE && speed_q != MinWide[SpeedW-1:0])
      |=> speed_setpoint_o == -$past(speed_setpoint_o))
    else $error("reverse transfer did not negate the set-point");

  a_hold_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |=> ($stable(speed_setpoint_o) && $stable(motor_enabled_o)))
    else $error("set-point changed without an input transfer");

endmodule
